/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: operation and
// status codes, sequencer states and stream beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    // default list depth
    localparam int CAPACITY_DEFAULT = 64;

    // field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // stream beat widths, fields packed from bit 0 and padded to bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

/* rtl/ple_ram.sv */
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with read, overwrite,
// insert-before and remove-at operations addressed by position.
// ----------------------------------------------------------------------------
// Usage:
//   One beat on the s_ channel carries one operation; one beat on the m_
//   channel carries its result (read value, element count, status).
//   s_tready is high only while the sequencer is idle; an operation is
//   worked off one step at a time through a single-port-pair RAM and one
//   shared index adder/comparator.
//   Every element moved by insert or remove costs one RAM read and one RAM
//   write, so the element shift loop sets the rate.
//   The result sits in an output register; the next beat can be taken while
//   it waits, but a finished result stalls in the sequencer until that
//   register is free, so a stalled receiver eventually holds off s_tready.
//   Reset empties the list (count zero) and clears the output valid; the
//   element RAM is not cleared, since no entry is read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // operation[1:0], position[8:2], new_value[40:9], zero pad to 48
    input  wire logic [ple_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // read_value[31:0], element_count[38:32], status[40:39], zero pad to 48
    output logic      [ple_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);

    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // sequencer and datapath registers
    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    op_t                  op_reg, op_next;
    status_t              status_reg, status_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [DATA_W-1:0]    rd_val_reg, rd_val_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // input beat fields
    op_t               in_op;
    logic [PW-1:0]     in_pos_w;
    logic [PW-1:0]     count_w;
    status_t           in_status;
    logic              s_accept;
    logic              out_free;

    // shared index unit
    logic [CW-1:0]     idx_succ_w;
    logic [AW-1:0]     idx_pred;
    logic [AW-1:0]     step_addr;
    logic              idx_gt_pos;
    logic              idx_more;
    logic              shift_more;

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_pos_w = PW'(s_tdata[8:2]);
    assign count_w  = PW'(count_reg);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // position check against the current count
    always_comb
    begin
        in_status = ST_OK;
        if (in_op == OP_INSERT)
        begin
            if (in_pos_w > count_w)
            begin
                in_status = ST_RANGE;
            end
            else if (count_w == PW'(CAPACITY))
            begin
                in_status = ST_FULL;
            end
        end
        else if (in_pos_w >= count_w)
        begin
            in_status = ST_RANGE;
        end
    end

    // index step: down for insert, up for remove
    assign idx_succ_w = CW'(idx_reg) + CW'(1);
    assign idx_pred   = idx_reg - AW'(1);
    assign step_addr  = (op_reg == OP_INSERT) ? idx_pred : AW'(idx_succ_w);
    assign idx_gt_pos = idx_reg > pos_reg;
    assign idx_more   = idx_succ_w < count_reg;
    assign shift_more = (op_reg == OP_INSERT) ? idx_gt_pos : idx_more;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (in_status == ST_OK) ? S_EXEC : S_FINISH;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_READ:   state_next = S_READ_WAIT;
                    OP_WRITE:  state_next = S_FINISH;
                    OP_INSERT,
                    OP_REMOVE: state_next = shift_more ? S_SHIFT_WR : S_FINISH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_READ_WAIT: state_next = S_FINISH;
            S_SHIFT_WR:  state_next = S_EXEC;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = step_addr;
        count_next    = count_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        rd_val_next   = rd_val_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept)
                begin
                    op_next     = in_op;
                    status_next = in_status;
                    pos_next    = AW'(s_tdata[8:2]);
                    val_next    = s_tdata[40:9];
                    idx_next    = (in_op == OP_INSERT) ? AW'(count_reg) : AW'(s_tdata[8:2]);
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_READ:
                    begin
                        ram_raddr = pos_reg;
                    end
                    OP_WRITE:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_reg;
                        ram_wdata = val_reg;
                    end
                    OP_INSERT:
                    begin
                        if (!idx_gt_pos)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pos_reg;
                            ram_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!idx_more)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                rd_val_next = ram_rdata;
            end
            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = step_addr;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[31:0]  = (op_reg == OP_READ && status_reg == ST_OK)
                                          ? rd_val_reg : '0;
                    m_tdata_next[38:32] = POS_W'(count_reg);
                    m_tdata_next[40:39] = status_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        rd_val_reg  <= rd_val_next;
        m_tdata_reg <= m_tdata_next;
    end

    // element store
    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/ple_checker.sv */
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [ple_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    import ple_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one operation at a time: busy right after an input beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an operation is in progress");

    // rejected operations return a zero read value
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[40:39] != ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("rejected operation returned data");

    // a full rejection reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[40:39] == ST_FULL) |-> (m_tdata[38:32] == POS_W'(CAPACITY)))
        else $error("list full status with count below capacity");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

`default_nettype wire

/* tb/tb_positional_list_engine.sv */
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Stream-level test of the positional list engine. A short directed run
// covers the empty list, inserts at the front, middle and end, reads, writes,
// removals and rejected positions. Random phases then grow the list until it
// is full, mix all operations and shrink it back to empty. Each result beat
// is checked field by field against a shadow copy of the list. Random gaps
// and stalls are applied on both sides, with one long receiver stall and a
// sender pause before each shrink phase until all results are back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_engine;

    import ple_pkg::*;

    localparam int CAP         = CAPACITY_DEFAULT;
    localparam int N_ITEMS     = 1350;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;

    // random phase kinds
    localparam int MODE_GROW   = 0;
    localparam int MODE_MIX    = 1;
    localparam int MODE_SHRINK = 2;

    typedef struct {
        op_t         op;
        logic [6:0]  pos;
        logic [31:0] val;
        int          gap;
        bit          drain;
    } list_req_t;

    typedef struct {
        logic [31:0] value;
        logic [6:0]  len;
        status_t     st;
    } list_resp_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // shadow list state
    logic [31:0] list_mem [CAP];
    int          list_len = 0;

    list_req_t  pending_reqs[$];
    list_resp_t expected_resps[$];

    int gen_len   = 0;
    int n_sent    = 0;
    int n_results = 0;
    int n_errors  = 0;
    int n_cycles  = 0;
    int n_ok      = 0;
    int n_range   = 0;
    int n_full    = 0;
    int peak_len  = 0;

    positional_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #2 clk = ~clk;

    // apply one operation to the shadow list and return its result
    function automatic list_resp_t predict_list_op(input list_req_t req);
        list_resp_t resp;
        int         p;
        p          = req.pos;
        resp.value = '0;
        resp.st    = ST_OK;
        if (req.op == OP_INSERT)
        begin
            if (p > list_len)
                resp.st = ST_RANGE;
            else if (list_len >= CAP)
                resp.st = ST_FULL;
            else
            begin
                for (int i = list_len; i > p; i--)
                    list_mem[i] = list_mem[i-1];
                list_mem[p] = req.val;
                list_len++;
            end
        end
        else if (p >= list_len)
            resp.st = ST_RANGE;
        else if (req.op == OP_READ)
            resp.value = list_mem[p];
        else if (req.op == OP_WRITE)
            list_mem[p] = req.val;
        else
        begin
            for (int i = p; i + 1 < list_len; i++)
                list_mem[i] = list_mem[i+1];
            list_len--;
        end
        resp.len = list_len[6:0];
        return resp;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // queue one operation and track the list length it leaves behind
    task automatic queue_req(input op_t op, input logic [6:0] pos, input logic [31:0] val,
                             input int gap, input bit drain);
        list_req_t req;
        req.op    = op;
        req.pos   = pos;
        req.val   = val;
        req.gap   = gap;
        req.drain = drain;
        pending_reqs.push_back(req);
        if (op == OP_INSERT && pos <= gen_len && gen_len < CAP)
            gen_len++;
        else if (op == OP_REMOVE && pos < gen_len)
            gen_len--;
    endtask

    // random operation biased by phase kind, positions mostly legal
    task automatic queue_random(input int mode, input bit calm, input bit drain);
        op_t        op;
        int         r;
        int         hi;
        logic [6:0] pos;
        r = $urandom_range(99);
        case (mode)
            MODE_GROW:   op = (r < 75) ? OP_INSERT : ((r < 88) ? OP_READ : OP_WRITE);
            MODE_SHRINK: op = (r < 75) ? OP_REMOVE : ((r < 88) ? OP_READ : OP_WRITE);
            default:     op = op_t'($urandom_range(3));
        endcase
        hi = (op == OP_INSERT) ? gen_len : gen_len - 1;
        r  = $urandom_range(99);
        if (r < 12 || hi < 0)
            pos = 7'($urandom_range(127));
        else if (r < 24)
            pos = '0;
        else if (r < 36)
            pos = 7'(hi);
        else
            pos = 7'($urandom_range(hi));
        queue_req(op, pos, $urandom, pick_gap(calm), drain);
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch at result %0d: %s expected %0h got %0h", n_results, what, want, got);
        n_errors++;
    endtask

    // driver: offer queued operations, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        list_req_t head;
        list_req_t in_flight;
        int        idle_cycles;
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            idle_cycles = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_resps.push_back(predict_list_op(in_flight));
                n_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && idle_cycles >= pending_reqs[0].gap
                    && !(pending_reqs[0].drain && expected_resps.size() != 0))
                begin
                    head        = pending_reqs.pop_front();
                    in_flight   = head;
                    idle_cycles = 0;
                    s_tdata     <= {7'd0, head.val, head.pos, head.op};
                    s_tvalid    <= 1'b1;
                end
                else
                begin
                    idle_cycles++;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure: random stalls, calm stretches, one long hold
    always @(posedge clk or negedge rst_n)
    begin : ready_proc
        int hold_left;
        bit long_hold_done;
        if (!rst_n)
        begin
            m_tready       <= 1'b0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && n_results >= 300)
        begin
            long_hold_done = 1'b1;
            hold_left      = 499;
            m_tready       <= 1'b0;
        end
        else if ((n_results / 150) % 4 != 1 && $urandom_range(99) < 12)
        begin
            hold_left = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        list_resp_t  want;
        logic [31:0] got_val;
        logic [6:0]  got_len;
        logic [1:0]  got_st;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_val = m_tdata[31:0];
            got_len = m_tdata[38:32];
            got_st  = m_tdata[40:39];
            n_results++;
            if (expected_resps.size() == 0)
                report("unexpected result beat", '0, got_val);
            else
            begin
                want = expected_resps.pop_front();
                if (got_val !== want.value)
                    report("read_value", want.value, got_val);
                if (got_len !== want.len)
                    report("element_count", 32'(want.len), 32'(got_len));
                if (got_st !== want.st)
                    report("status", 32'(want.st), 32'(got_st));
                case (want.st)
                    ST_OK:    n_ok++;
                    ST_RANGE: n_range++;
                    default:  n_full++;
                endcase
                if (want.len > peak_len)
                    peak_len = want.len;
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("[positional_list_engine] ERROR");
            $finish;
        end
    end

    initial
    begin : stim_proc
        int phase;
        bit calm;

        // empty list: everything but insert at zero is rejected
        queue_req(OP_READ,   7'd0,   32'h1234_5678, pick_gap(0), 1'b0);
        queue_req(OP_WRITE,  7'd0,   32'h1234_5678, pick_gap(0), 1'b0);
        queue_req(OP_REMOVE, 7'd0,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_INSERT, 7'd1,   32'h1,         pick_gap(0), 1'b0);
        queue_req(OP_INSERT, 7'd127, 32'hFFFF_FFFF, pick_gap(0), 1'b0);
        // build a short list: front, front, end, middle
        queue_req(OP_INSERT, 7'd0,   32'h7FFF_FFFF, pick_gap(0), 1'b0);
        queue_req(OP_INSERT, 7'd0,   32'h8000_0000, pick_gap(0), 1'b0);
        queue_req(OP_INSERT, 7'd2,   32'hFFFF_FFFF, pick_gap(0), 1'b0);
        queue_req(OP_INSERT, 7'd1,   32'h0,         pick_gap(0), 1'b0);
        for (int i = 0; i < 4; i++)
            queue_req(OP_READ, 7'(i), $urandom, pick_gap(0), 1'b0);
        // reads past the end
        queue_req(OP_READ,   7'd4,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_READ,   7'd127, 32'h0,         pick_gap(0), 1'b0);
        // overwrite with alternating bit patterns
        queue_req(OP_WRITE,  7'd2,   32'h5555_5555, pick_gap(0), 1'b0);
        queue_req(OP_READ,   7'd2,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_WRITE,  7'd0,   32'hAAAA_AAAA, pick_gap(0), 1'b0);
        // remove middle, last, front, then drain to empty
        queue_req(OP_REMOVE, 7'd1,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_REMOVE, 7'd2,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_REMOVE, 7'd0,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_READ,   7'd0,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_REMOVE, 7'd0,   32'h0,         pick_gap(0), 1'b0);
        queue_req(OP_REMOVE, 7'd0,   32'h0,         pick_gap(0), 1'b0);

        // random phases: fill to full, mixed traffic, empty out again
        phase = 0;
        while (pending_reqs.size() < N_ITEMS)
        begin
            calm = (phase % 4 == 3);
            case (phase % 3)
                MODE_GROW:
                begin
                    while (gen_len < CAP)
                        queue_random(MODE_GROW, calm, 1'b0);
                    for (int i = 0; i < 8; i++)
                        queue_random(MODE_GROW, calm, 1'b0);
                end
                MODE_MIX:
                    for (int i = 0; i < 150; i++)
                        queue_random(MODE_MIX, calm, 1'b0);
                default:
                begin
                    queue_random(MODE_SHRINK, calm, 1'b1);
                    while (gen_len > 0)
                        queue_random(MODE_SHRINK, calm, 1'b0);
                    for (int i = 0; i < 6; i++)
                        queue_random(MODE_SHRINK, calm, 1'b0);
                end
            endcase
            phase++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait until all operations are sent and all results are back,
        // sampled between edges so the driver and monitor have settled
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_resps.size() != 0)
            report("results still outstanding", '0, 32'(expected_resps.size()));

        $display("ran %0d operations, checked %0d results in %0d cycles",
                 n_sent, n_results, n_cycles);
        $display("status mix: %0d ok, %0d out of range, %0d full; peak length %0d",
                 n_ok, n_range, n_full, peak_len);
        if (n_errors == 0)
            $display("[positional_list_engine] OK");
        else
            $display("[positional_list_engine] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
